// ===== sv/zzrf_pkg.sv =====
// ----------------------------------------------------------------------------
// zzrf_pkg: shared types and constants for the zigzag rail fence permuter
// Holds the message capacity, derived widths and the structs that travel
// between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
package zzrf_pkg;

  // Message capacity in bytes per bank.
  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  // Wide enough to hold MAX_LEN itself.
  localparam int CNT_W   = ADDR_W + 1;
  // Candidate positions stay below three times the capacity.
  localparam int POS_W   = ADDR_W + 2;
  // Width of the rail count register.
  localparam int ROWS_W  = 7;
  // Two banks, so two jobs in flight at most.
  localparam int QDEPTH  = 2;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_last;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic       overflow;
  } out_word_t;

  // One finished message waiting to be reordered.
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] len;
    logic             ovf;
  } job_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W:0]   addr;
    logic [7:0]        data;
  } mem_wr_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W:0]   addr;
  } mem_rd_t;

endpackage

// ===== sv/zzrf_front.sv =====
// ----------------------------------------------------------------------------
// zzrf_front: message loader
// Accepts words, writes bytes into the current bank, counts them, notes
// truncation and hands a finished message to the job queue.
// ----------------------------------------------------------------------------
module zzrf_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  zzrf_pkg::in_word_t in_word,
  output zzrf_pkg::mem_wr_t mem_wr,
  output logic              push,
  output zzrf_pkg::job_t    push_job
);
  import zzrf_pkg::*;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             ovf_r, ovf_nxt;
  logic             bank_r, bank_nxt;
  logic             full;

  assign full = (cnt_r == CNT_W'(MAX_LEN));

  always_comb begin
    cnt_nxt  = cnt_r;
    ovf_nxt  = ovf_r;
    bank_nxt = bank_r;

    mem_wr.we   = accept && !full;
    mem_wr.addr = {bank_r, cnt_r[ADDR_W-1:0]};
    mem_wr.data = in_word.data_byte;

    push          = accept && in_word.is_last;
    push_job.bank = bank_r;
    push_job.len  = full ? cnt_r : cnt_r + CNT_W'(1);
    push_job.ovf  = ovf_r || full;

    if (accept) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
      if (in_word.is_last) begin
        cnt_nxt  = '0;
        ovf_nxt  = 1'b0;
        bank_nxt = !bank_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ovf_r  <= 1'b0;
      bank_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ovf_r  <= ovf_nxt;
      bank_r <= bank_nxt;
    end
  end

endmodule

// ===== sv/zzrf_queue.sv =====
// ----------------------------------------------------------------------------
// zzrf_queue: job queue between loader and emitter
// Two-entry queue of finished messages. An entry stays until the emitter
// has issued the last read of its bank, so a full queue means both banks
// are taken.
// ----------------------------------------------------------------------------
module zzrf_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  zzrf_pkg::job_t push_job,
  input  logic           pop,
  output zzrf_pkg::job_t head,
  output logic           empty,
  output logic           full
);
  import zzrf_pkg::*;

  job_t              entry_r [QDEPTH];
  logic              wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r, count_nxt;

  assign head  = entry_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign full  = (count_r == QCNT_W'(QDEPTH));

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("job popped from an empty queue");

endmodule

// ===== sv/zzrf_back.sv =====
// ----------------------------------------------------------------------------
// zzrf_back: rail order sequencer
// Walks the rails of the head job one candidate position a cycle, issues
// a store read for every position inside the message and marks the last.
// ----------------------------------------------------------------------------
module zzrf_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [zzrf_pkg::ROWS_W-1:0] num_rows,
  input  zzrf_pkg::job_t            head,
  input  logic                      q_empty,
  output logic                      q_pop,
  output zzrf_pkg::mem_rd_t         mem_rd,
  output logic                      strobe,
  output logic                      last,
  output logic                      ovf
);
  import zzrf_pkg::*;

  logic              active_r, active_nxt;
  logic              straight_r, straight_nxt;
  logic              bank_r, bank_nxt;
  logic              jovf_r, jovf_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] rows_r, rows_nxt;
  logic [POS_W-1:0]  cyc_r, cyc_nxt;
  logic [ADDR_W-1:0] row_r, row_nxt;
  logic [POS_W-1:0]  base_r, base_nxt;
  logic              phase_r, phase_nxt;
  logic [ADDR_W-1:0] cnt_r, cnt_nxt;
  logic              strobe_r, last_r, ovf_r;

  logic [POS_W-1:0]  cand;
  logic [POS_W-1:0]  next_base;
  logic              hit, done_hit, middle;

  always_comb begin
    if (straight_r) begin
      cand = POS_W'(cnt_r);
    end else if (phase_r) begin
      cand = base_r + cyc_r - POS_W'(row_r);
    end else begin
      cand = base_r + POS_W'(row_r);
    end
    hit       = active_r && (cand < POS_W'(len_r));
    done_hit  = hit && (CNT_W'(cnt_r) == len_r - CNT_W'(1));
    middle    = (row_r != '0) && (row_r != rows_r - ADDR_W'(1));
    next_base = base_r + cyc_r;
  end

  assign q_pop       = done_hit;
  assign mem_rd.en   = hit;
  assign mem_rd.addr = {bank_r, cand[ADDR_W-1:0]};

  always_comb begin
    active_nxt   = active_r;
    straight_nxt = straight_r;
    bank_nxt     = bank_r;
    jovf_nxt     = jovf_r;
    len_nxt      = len_r;
    rows_nxt     = rows_r;
    cyc_nxt      = cyc_r;
    row_nxt      = row_r;
    base_nxt     = base_r;
    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;

    if (!active_r) begin
      if (!q_empty) begin
        active_nxt   = 1'b1;
        bank_nxt     = head.bank;
        jovf_nxt     = head.ovf;
        len_nxt      = head.len;
        straight_nxt = (num_rows <= ROWS_W'(1)) || (num_rows >= ROWS_W'(head.len));
        rows_nxt     = num_rows[ADDR_W-1:0];
        cyc_nxt      = POS_W'({num_rows, 1'b0}) - POS_W'(2);
        row_nxt      = '0;
        base_nxt     = '0;
        phase_nxt    = 1'b0;
        cnt_nxt      = '0;
      end
    end else begin
      if (hit) begin
        cnt_nxt = cnt_r + ADDR_W'(1);
      end
      if (!straight_r) begin
        if (!phase_r && middle) begin
          phase_nxt = 1'b1;
        end else begin
          phase_nxt = 1'b0;
          if (next_base >= POS_W'(len_r)) begin
            base_nxt = '0;
            row_nxt  = row_r + ADDR_W'(1);
          end else begin
            base_nxt = next_base;
          end
        end
      end
      if (done_hit) begin
        active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    straight_r <= straight_nxt;
    bank_r     <= bank_nxt;
    jovf_r     <= jovf_nxt;
    len_r      <= len_nxt;
    rows_r     <= rows_nxt;
    cyc_r      <= cyc_nxt;
    row_r      <= row_nxt;
    base_r     <= base_nxt;
    phase_r    <= phase_nxt;
    cnt_r      <= cnt_nxt;
    last_r     <= done_hit;
    ovf_r      <= jovf_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      strobe_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
      strobe_r <= hit;
    end
  end

  assign strobe = strobe_r;
  assign last   = last_r;
  assign ovf    = ovf_r;

  a_read_in_message: assert property (@(posedge clk) disable iff (!rst_n)
    mem_rd.en |-> (cand < POS_W'(len_r)))
    else $error("store read beyond the message length");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (!active_r && strobe_r && last_r))
    else $error("sequencer did not close the job after its last read");

endmodule

// ===== sv/zigzag_rail_fence_permuter.sv =====
// ----------------------------------------------------------------------------
// zigzag_rail_fence_permuter: rail fence reordering of byte messages
// Flow: the queue registers a finished message, the idle emitter loads it as a
//   job and issues its reads, and each reordered word leaves from the registered
//   read data and flags; later words follow one per cycle while positions hit.
// Loading: one word per cycle while busy is low; the loader fills one bank
//   while the emitter still reads the message in the other.
// Reset: synchronous, active low; clears counts, queue and sequencer, sets
//   the rail count to one. The results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module zigzag_rail_fence_permuter (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  zzrf_pkg::in_word_t          in_word,
  output logic                        out_strobe,
  output zzrf_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic [zzrf_pkg::ROWS_W-1:0] cfg_wdata
);
  import zzrf_pkg::*;

  // The block is split into a loader (front), a two-entry job queue and
  // an emitter (back). The store holds two banks of MAX_LEN bytes, so the
  // loader fills one bank while the emitter reads the other one.

  logic [ROWS_W-1:0] num_rows_r;

  logic    accept;
  mem_wr_t mem_wr;
  mem_rd_t mem_rd;
  logic    push, pop, q_empty, q_full;
  job_t    push_job, head;
  logic    bk_strobe, bk_last, bk_ovf;

  logic [7:0] store_mem [2*MAX_LEN];
  logic [7:0] rd_data_r;

  // A word is taken whenever a bank is free: the queue only fills up when
  // both banks hold messages that still wait for emission.
  assign busy   = q_full;
  assign accept = start && !busy;

  // The user must write the rail count only while the block is idle (the block
  // does not enforce it), so the emitter may sample it when a job starts.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= ROWS_W'(1);
    end else if (cfg_we) begin
      num_rows_r <= cfg_wdata;
    end
  end

  zzrf_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (accept),
    .in_word  (in_word),
    .mem_wr   (mem_wr),
    .push     (push),
    .push_job (push_job)
  );

  zzrf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty),
    .full     (q_full)
  );

  zzrf_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .num_rows (num_rows_r),
    .head     (head),
    .q_empty  (q_empty),
    .q_pop    (pop),
    .mem_rd   (mem_rd),
    .strobe   (bk_strobe),
    .last     (bk_last),
    .ovf      (bk_ovf)
  );

  // Message store: one write port for the loader, one registered read
  // port for the emitter. The emitter frees a bank only at the edge that
  // takes its final read, so the loader never overwrites unread bytes.
  always_ff @(posedge clk) begin
    if (mem_wr.we) begin
      store_mem[mem_wr.addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_rd.en) begin
      rd_data_r <= store_mem[mem_rd.addr];
    end
  end

  // The read data and the emitter's flags were registered on the same
  // edge, so the result word leaves straight from registers.
  assign out_strobe        = bk_strobe;
  assign out_word.out_byte = rd_data_r;
  assign out_word.out_last = bk_last;
  assign out_word.overflow = bk_ovf;

endmodule

// ===== sim/zzrf_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zzrf_checker: scoreboard for the zigzag rail fence permuter
// Watches the input, result and rail count ports and keeps its own copy of
// the message. It predicts the reordered words of each message and compares
// every result word, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
module zzrf_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  zzrf_pkg::in_word_t          in_word,
  input  logic                        out_strobe,
  input  zzrf_pkg::out_word_t         out_word,
  input  logic                        cfg_we,
  input  logic [zzrf_pkg::ROWS_W-1:0] cfg_wdata,
  output int                          fail_count,
  output int                          pending_words,
  output int                          words_checked
);

  logic [7:0]                  msg_mem [zzrf_pkg::MAX_LEN];
  int                          held_len;
  logic                        held_ovf;
  logic [zzrf_pkg::ROWS_W-1:0] rails;
  zzrf_pkg::out_word_t         reordered_q [$];

  initial begin
    fail_count    = 0;
    pending_words = 0;
    words_checked = 0;
    held_len      = 0;
    held_ovf      = 1'b0;
    rails         = 1;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("ERROR: %s: got 0x%0h, expected 0x%0h (word %0d)", what, got, want,
             words_checked);
    fail_count++;
  endtask

  // Lists the stored positions rail by rail and queues the words they select.
  task automatic predict_reorder();
    int                  len;
    int                  rows;
    int                  cyc;
    int                  r;
    int                  base;
    int                  p;
    int                  n;
    int                  i;
    int                  pos [$];
    zzrf_pkg::out_word_t w;
    len  = held_len;
    rows = rails;
    if (rows <= 1 || rows >= len) begin
      for (i = 0; i < len; i++) pos.push_back(i);
    end else begin
      cyc = 2 * (rows - 1);
      for (r = 0; r < rows; r++) begin
        for (base = 0; base < len; base += cyc) begin
          p = base + r;
          if (p < len) pos.push_back(p);
          if (r != 0 && r != rows - 1) begin
            p = base + cyc - r;
            if (p < len) pos.push_back(p);
          end
        end
      end
    end
    n = pos.size();
    for (i = 0; i < n; i++) begin
      w.out_byte = msg_mem[pos[i]];
      w.out_last = (i == n - 1);
      w.overflow = held_ovf;
      reordered_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    zzrf_pkg::out_word_t want;
    if (!rst_n) begin
      held_len = 0;
      held_ovf = 1'b0;
      rails    = 1;
      reordered_q.delete();
    end else begin
      if (cfg_we) rails = cfg_wdata;
      if (out_strobe) begin
        if (reordered_q.size() == 0) begin
          report_mismatch("result word with nothing expected", out_word, 0);
        end else begin
          want = reordered_q.pop_front();
          if (out_word.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_word.out_byte, want.out_byte);
          if (out_word.out_last !== want.out_last)
            report_mismatch("out_last", out_word.out_last, want.out_last);
          if (out_word.overflow !== want.overflow)
            report_mismatch("overflow", out_word.overflow, want.overflow);
        end
        words_checked++;
      end
      if (start && !busy) begin
        if (held_len < zzrf_pkg::MAX_LEN) begin
          msg_mem[held_len] = in_word.data_byte;
          held_len++;
        end else begin
          held_ovf = 1'b1;
        end
        if (in_word.is_last) begin
          predict_reorder();
          held_len = 0;
          held_ovf = 1'b0;
        end
      end
    end
    pending_words = reordered_q.size();
  end

endmodule

// ===== sim/tb_zigzag_rail_fence_permuter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_zigzag_rail_fence_permuter: top of the permuter testbench
// Drives messages word by word into the permuter, changes the rail count
// between messages and leaves the checking to the scoreboard beside it.
// ----------------------------------------------------------------------------
module tb_zigzag_rail_fence_permuter;

  // Far above the slowest legal run: every message emitted at the slowest
  // rail setting, every word preceded by the longest sender gap.
  localparam int CYCLE_LIMIT  = 300000;
  // Words sent in the random part before the stimulus stops.
  localparam int RANDOM_WORDS = 350;
  // From this word count on, the sender no longer idles.
  localparam int QUIET_FROM   = 300;
  // Settling time after the last expected word, well above the latency.
  localparam int SETTLE       = 10;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  zzrf_pkg::in_word_t          in_word;
  logic                        out_strobe;
  zzrf_pkg::out_word_t         out_word;
  logic                        cfg_we;
  logic [zzrf_pkg::ROWS_W-1:0] cfg_wdata;

  int fail_count;
  int pending_words;
  int words_checked;
  int cycle_count;
  int words_sent;
  int messages_sent;
  int truncated_sent;
  int settings_used;

  zigzag_rail_fence_permuter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_word    (in_word),
    .out_strobe (out_strobe),
    .out_word   (out_word),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  zzrf_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_word       (in_word),
    .out_strobe    (out_strobe),
    .out_word      (out_word),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .pending_words (pending_words),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost word ends the run here.
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("ERROR: cycle limit reached with %0d words still expected", pending_words);
      $display("simulation failed");
      $finish;
    end
  end

  // Offers one word from a falling edge and holds it until the rising edge
  // at which busy is low. Start is left high, so that a following word goes
  // out back to back; only an idle gap lowers it.
  task automatic send_word(input logic [7:0] data, input logic last);
    in_word <= '{data_byte: data, is_last: last};
    start   <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  // A burst of sender idling, with start low and a random filler word.
  task automatic idle_gap();
    start   <= 1'b0;
    in_word <= zzrf_pkg::in_word_t'($urandom);
    repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  // Sends a whole message of random bytes; the last word carries the flag.
  task automatic send_message(input int len);
    int i;
    for (i = 0; i < len; i++) begin
      if (words_sent < QUIET_FROM && $urandom_range(0, 5) == 0) idle_gap();
      send_word($urandom_range(0, 255), i == len - 1);
    end
    messages_sent++;
    if (len > zzrf_pkg::MAX_LEN) truncated_sent++;
  endtask

  // Holds the sender back until every predicted word has come out, then waits
  // out the SETTLE time, so that the block is surely idle.
  task automatic wait_drained();
    start <= 1'b0;
    while (pending_words != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Writing the rail count is only done with the block idle.
  task automatic set_rails(input int rows);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= rows[zzrf_pkg::ROWS_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    // Rail settings and first message lengths for the opening random phases:
    // over-long messages, a message exactly at capacity with as many rails
    // as bytes, one rail short of that, and the rail counts of zero and one.
    int fixed_rows [8] = '{2, 3, 5, 64, 63, 127, 0, 1};
    int fixed_len  [8] = '{70, 20, 33, 64, 64, 65, 66, 2};
    int phase;
    int rows;
    int n_msgs;
    int m;
    int len;

    start      <= 1'b0;
    in_word    <= '0;
    cfg_we     <= 1'b0;
    cfg_wdata  <= '0;
    rst_n      <= 1'b0;
    words_sent     = 0;
    messages_sent  = 0;
    truncated_sent = 0;
    settings_used  = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. The rail count still holds its reset value of one here,
    // so the first two messages must come out unchanged: a single word
    // message with a zero byte, then the byte extremes and a 5A byte in order.
    send_word(8'h00, 1'b1);
    send_word(8'hFF, 1'b0);
    send_word(8'h00, 1'b0);
    send_word(8'h5A, 1'b1);
    messages_sent += 2;

    // Two rails: even positions first, then odd ones.
    set_rails(2);
    send_word(8'h00, 1'b0);
    send_word(8'hFF, 1'b0);
    send_message(3);
    messages_sent--;
    messages_sent++;

    // Three rails over nine bytes exercises a middle rail taking two
    // positions per zigzag cycle.
    set_rails(3);
    send_message(9);

    // Zero rails behaves as one rail.
    set_rails(0);
    send_message(3);

    // The widest rail count is far beyond the message, so nothing moves.
    set_rails(127);
    send_message(4);

    // Random part: each phase picks a rail count, writes it while idle and
    // sends a few messages, mostly short so that zigzags wrap several times,
    // now and then long enough to fill and overrun the store.
    words_sent = 0;
    phase      = 0;
    while (words_sent < RANDOM_WORDS) begin
      if (phase < 8) begin
        rows = fixed_rows[phase];
      end else if ($urandom_range(0, 9) < 7) begin
        rows = $urandom_range(2, 12);
      end else begin
        rows = $urandom_range(0, 127);
      end
      set_rails(rows);
      n_msgs = $urandom_range(2, 5);
      for (m = 0; m < n_msgs && words_sent < RANDOM_WORDS; m++) begin
        if (phase < 8 && m == 0) begin
          len = fixed_len[phase];
        end else if ($urandom_range(0, 99) < 8) begin
          len = $urandom_range(60, 72);
        end else begin
          len = $urandom_range(1, 24);
        end
        send_message(len);
        if (words_sent < QUIET_FROM && $urandom_range(0, 3) == 0) idle_gap();
      end
      phase++;
    end

    wait_drained();
    $display("Covered %0d messages (%0d overran the store) over %0d rail settings,",
             messages_sent, truncated_sent, settings_used);
    $display("with %0d reordered words checked in %0d cycles.", words_checked, cycle_count);
    if (fail_count == 0 && pending_words == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
